/* rtl/sfpx_pkg.sv */
package sfpx_pkg;

  localparam int MAX_PAYLOAD = 16;
  localparam int IDX_W = $clog2(MAX_PAYLOAD);
  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [31:0] TIMEOUT_RESET = 32'd50;

  // result status codes
  localparam logic [1:0] STATUS_PROGRESS = 2'd0;
  localparam logic [1:0] STATUS_OK = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [31:0] timestamp;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] command;
    logic [4:0] length;
    logic [7:0] payload_byte;
    logic [3:0] byte_index;
    logic last;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_WAIT_SOF,
    ST_CMD,
    ST_LEN,
    ST_DATA,
    ST_SUM,
    ST_DRAIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic set_time;
    logic load_cmd;
    logic load_len;
    logic store_data;
    logic emit;
    logic [1:0] emit_status;
    logic emit_frame;
    logic drain_start;
    logic drain_emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic is_sof;
    logic timed_out;
    logic len_bad;
    logic byte_zero;
    logic frame_len_zero;
    logic fill_last;
    logic sum_good;
    logic drain_last;
  } dp_status_t;

endpackage

/* rtl/serial_frame_parser_xor_timeout_core.sv */
// Serial frame parser: takes one received byte with its millisecond timestamp per request and
// parses frames of start byte 0xAA, command, length (0 to 16), payload and an XOR checksum over
// command, length and payload. Every byte gives one result with status 0 (in progress), except
// a bad length or checksum (status 2, one result), an inter-byte gap beyond timeout_ms inside an
// open frame (status 3, one result, the same byte then restarts parsing and may open a frame),
// and a good checksum byte, which gives one status 1 result per payload byte or a single one for
// an empty frame. A good frame then holds off input while the payload store is read out one
// entry a cycle whenever the receiver is not stalling. A single output register sits on the
// result side, so a new byte is taken in the same cycle that the previous result leaves.
// timeout_ms resets to 50 and zero disables the check; the user must write it only while the
// block is idle, since the block itself does not enforce this.
module serial_frame_parser_xor_timeout_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sfpx_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sfpx_pkg::out_req_t out_data,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);

  // command and status between the frame controller and the datapath
  sfpx_pkg::dp_cmd_t    cmd;
  sfpx_pkg::dp_status_t sts;

  // frame state machine, also owns the input handshake
  sfpx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // frame registers, payload store, timeout compare and result register
  sfpx_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* rtl/sfpx_ctrl.sv */
module sfpx_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sfpx_pkg::dp_status_t sts,
  output sfpx_pkg::dp_cmd_t    cmd
);

  sfpx_pkg::state_t state, state_next;
  logic accept;
  logic timeout_hit;

  assign in_stall = (state == sfpx_pkg::ST_DRAIN) || !sts.out_free;
  assign accept = in_valid && !in_stall;
  assign timeout_hit = (state != sfpx_pkg::ST_WAIT_SOF) && sts.timed_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfpx_pkg::ST_WAIT_SOF;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    if (state == sfpx_pkg::ST_DRAIN) begin
      if (sts.out_free && sts.drain_last) begin
        state_next = sfpx_pkg::ST_WAIT_SOF;
      end
    end else if (accept) begin
      if (timeout_hit) begin
        state_next = sts.is_sof ? sfpx_pkg::ST_CMD : sfpx_pkg::ST_WAIT_SOF;
      end else begin
        case (state)
          sfpx_pkg::ST_WAIT_SOF: begin
            if (sts.is_sof) state_next = sfpx_pkg::ST_CMD;
          end
          sfpx_pkg::ST_CMD: state_next = sfpx_pkg::ST_LEN;
          sfpx_pkg::ST_LEN: begin
            if (sts.len_bad) state_next = sfpx_pkg::ST_WAIT_SOF;
            else if (sts.byte_zero) state_next = sfpx_pkg::ST_SUM;
            else state_next = sfpx_pkg::ST_DATA;
          end
          sfpx_pkg::ST_DATA: begin
            if (sts.fill_last) state_next = sfpx_pkg::ST_SUM;
          end
          sfpx_pkg::ST_SUM: begin
            if (sts.sum_good && !sts.frame_len_zero) state_next = sfpx_pkg::ST_DRAIN;
            else state_next = sfpx_pkg::ST_WAIT_SOF;
          end
          default: state_next = sfpx_pkg::ST_WAIT_SOF;
        endcase
      end
    end
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    cmd.emit_status = sfpx_pkg::STATUS_PROGRESS;
    if (state == sfpx_pkg::ST_DRAIN) begin
      cmd.drain_emit = sts.out_free;
    end else if (accept) begin
      if (timeout_hit) begin
        cmd.emit = 1'b1;
        cmd.emit_status = sfpx_pkg::STATUS_TIMEOUT;
        cmd.set_time = sts.is_sof;
      end else begin
        case (state)
          sfpx_pkg::ST_WAIT_SOF: begin
            cmd.emit = 1'b1;
            cmd.set_time = sts.is_sof;
          end
          sfpx_pkg::ST_CMD: begin
            cmd.emit = 1'b1;
            cmd.load_cmd = 1'b1;
            cmd.set_time = 1'b1;
          end
          sfpx_pkg::ST_LEN: begin
            cmd.emit = 1'b1;
            if (sts.len_bad) begin
              cmd.emit_status = sfpx_pkg::STATUS_ERROR;
            end else begin
              cmd.load_len = 1'b1;
              cmd.set_time = 1'b1;
            end
          end
          sfpx_pkg::ST_DATA: begin
            cmd.emit = 1'b1;
            cmd.store_data = 1'b1;
            cmd.set_time = 1'b1;
          end
          sfpx_pkg::ST_SUM: begin
            if (!sts.sum_good) begin
              cmd.emit = 1'b1;
              cmd.emit_status = sfpx_pkg::STATUS_ERROR;
            end else if (sts.frame_len_zero) begin
              cmd.emit = 1'b1;
              cmd.emit_status = sfpx_pkg::STATUS_OK;
              cmd.emit_frame = 1'b1;
            end else begin
              cmd.drain_start = 1'b1;
            end
          end
          default: cmd = '0;
        endcase
      end
    end
  end

endmodule

/* rtl/sfpx_dp.sv */
module sfpx_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  sfpx_pkg::in_req_t    in_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output sfpx_pkg::out_req_t   out_data,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata,
  input  sfpx_pkg::dp_cmd_t    cmd,
  output sfpx_pkg::dp_status_t sts
);

  logic [31:0] timeout_ms;
  logic [31:0] last_byte_time;
  logic [7:0] frame_command;
  logic [4:0] frame_length;
  logic [7:0] running_xor;
  logic [4:0] fill_index;
  logic [sfpx_pkg::IDX_W-1:0] drain_idx;
  logic [7:0] payload_store [sfpx_pkg::MAX_PAYLOAD];
  logic [31:0] elapsed;
  logic [4:0] fill_count;

  assign elapsed = in_data.timestamp - last_byte_time;
  assign fill_count = fill_index + 5'd1;

  always_comb begin
    sts.out_free = !out_valid || !out_stall;
    sts.is_sof = (in_data.rx_byte == sfpx_pkg::START_BYTE);
    sts.timed_out = (timeout_ms != 32'd0) && (elapsed > timeout_ms);
    sts.len_bad = (in_data.rx_byte > 8'(sfpx_pkg::MAX_PAYLOAD));
    sts.byte_zero = (in_data.rx_byte == 8'd0);
    sts.frame_len_zero = (frame_length == 5'd0);
    sts.fill_last = (fill_count >= frame_length);
    sts.sum_good = (in_data.rx_byte == running_xor);
    sts.drain_last = (5'(drain_idx) == frame_length - 5'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= sfpx_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ms <= cfg_wdata;
    end
  end

  // frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_byte_time <= '0;
      frame_command <= '0;
      frame_length <= '0;
      running_xor <= '0;
      fill_index <= '0;
      drain_idx <= '0;
    end else begin
      if (cmd.set_time) last_byte_time <= in_data.timestamp;
      if (cmd.load_cmd) begin
        frame_command <= in_data.rx_byte;
        running_xor <= in_data.rx_byte;
      end
      if (cmd.load_len) begin
        frame_length <= in_data.rx_byte[4:0];
        running_xor <= running_xor ^ in_data.rx_byte;
        fill_index <= '0;
      end
      if (cmd.store_data) begin
        running_xor <= running_xor ^ in_data.rx_byte;
        fill_index <= fill_count;
      end
      if (cmd.drain_start) drain_idx <= '0;
      else if (cmd.drain_emit) drain_idx <= drain_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_data && (fill_index < 5'(sfpx_pkg::MAX_PAYLOAD))) begin
      payload_store[fill_index[sfpx_pkg::IDX_W-1:0]] <= in_data.rx_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.drain_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_emit) begin
      out_data.status <= sfpx_pkg::STATUS_OK;
      out_data.command <= frame_command;
      out_data.length <= frame_length;
      out_data.payload_byte <= payload_store[drain_idx];
      out_data.byte_index <= 4'(drain_idx);
      out_data.last <= sts.drain_last;
    end else if (cmd.emit) begin
      out_data.status <= cmd.emit_status;
      out_data.command <= cmd.emit_frame ? frame_command : 8'd0;
      out_data.length <= cmd.emit_frame ? frame_length : 5'd0;
      out_data.payload_byte <= 8'd0;
      out_data.byte_index <= 4'd0;
      out_data.last <= 1'b1;
    end
  end

endmodule

/* rtl/sfpx_checker.sv */
module sfpx_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input sfpx_pkg::out_req_t out_data
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  // anything but a good frame is a single cleared result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != sfpx_pkg::STATUS_OK) |->
      out_data.last && (out_data.command == 8'd0) && (out_data.length == 5'd0))
    else $error("non-frame result not cleared");

  // a result before the end of a payload run points inside the payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == sfpx_pkg::STATUS_OK) && !out_data.last |->
      (({1'b0, out_data.byte_index} + 5'd1) < out_data.length))
    else $error("payload run index out of range");

  // an empty good frame gives one result with no payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == sfpx_pkg::STATUS_OK) && (out_data.length == 5'd0) |->
      out_data.last && (out_data.byte_index == 4'd0) && (out_data.payload_byte == 8'd0))
    else $error("empty frame result malformed");

endmodule

bind serial_frame_parser_xor_timeout_core sfpx_checker u_sfpx_checker (.*);

/* test/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // no progress on either channel for this many cycles means the block hung
  localparam int WATCHDOG_LIMIT = 3000;
  // cycles the receiver holds off in one stretch to back the block up
  localparam int CHOKE_CYCLES = 80;
  localparam int PHASE_ITEMS = 65;
  localparam int N_PHASES = 6;

  // single results that can be read straight off the frame layout
  localparam sfpx_pkg::out_req_t R_PROGRESS =
    '{sfpx_pkg::STATUS_PROGRESS, 8'h00, 5'd0, 8'h00, 4'd0, 1'b1};
  localparam sfpx_pkg::out_req_t R_ERROR =
    '{sfpx_pkg::STATUS_ERROR, 8'h00, 5'd0, 8'h00, 4'd0, 1'b1};
  localparam sfpx_pkg::out_req_t R_TIMEOUT =
    '{sfpx_pkg::STATUS_TIMEOUT, 8'h00, 5'd0, 8'h00, 4'd0, 1'b1};
  localparam sfpx_pkg::out_req_t R_EMPTY_FF =
    '{sfpx_pkg::STATUS_OK, 8'hFF, 5'd0, 8'h00, 4'd0, 1'b1};
  localparam sfpx_pkg::out_req_t R_NONE = '0;

  typedef struct packed {
    logic [7:0] b;
    logic [31:0] t;
    logic pinned;    // expected result typed in below
    sfpx_pkg::out_req_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  sfpx_pkg::in_req_t in_data;
  logic out_valid;
  logic out_stall;
  sfpx_pkg::out_req_t out_data;
  logic cfg_we;
  logic [31:0] cfg_wdata;

  // parser state as the block should hold it
  sfpx_pkg::state_t frame_phase;
  logic [7:0] frame_cmd;
  logic [4:0] frame_len;
  logic [7:0] frame_xor;
  logic [4:0] fill_ptr;
  logic [7:0] payload_mem [16];
  logic [31:0] last_ms;
  logic [31:0] timeout_q;

  sfpx_pkg::out_req_t step_results[$];     // results of the byte just parsed
  sfpx_pkg::out_req_t pending_results[$];  // results still owed by the block
  sfpx_pkg::out_req_t head_result;

  logic [31:0] clock_ms;
  int bytes_offered;
  int mismatches;
  int idle_cycles;
  bit calm;
  bit tx_quiet;
  bit rx_quiet;
  bit choke_req;

  // directed stimulus, timeout at its reset value of 50
  stim_row_t dir_rows [25] = '{
    // non-start bytes while waiting for a frame
    '{8'h00, 32'd0, 1'b1, R_PROGRESS},
    '{8'hFF, 32'd1, 1'b1, R_PROGRESS},
    // length just past the limit
    '{8'hAA, 32'd2, 1'b1, R_PROGRESS},
    '{8'h00, 32'd3, 1'b1, R_PROGRESS},
    '{8'h11, 32'd4, 1'b1, R_ERROR},
    // empty frame, checksum is command xor length
    '{8'hAA, 32'd5, 1'b1, R_PROGRESS},
    '{8'hFF, 32'd6, 1'b1, R_PROGRESS},
    '{8'h00, 32'd7, 1'b1, R_PROGRESS},
    '{8'hFF, 32'd8, 1'b1, R_EMPTY_FF},
    // one payload byte, wrong checksum
    '{8'hAA, 32'd9, 1'b1, R_PROGRESS},
    '{8'h12, 32'd10, 1'b1, R_PROGRESS},
    '{8'h01, 32'd11, 1'b1, R_PROGRESS},
    '{8'hAB, 32'd12, 1'b1, R_PROGRESS},
    '{8'h00, 32'd13, 1'b1, R_ERROR},
    // gap of 51 inside a frame, the start byte then reopens a frame
    '{8'hAA, 32'd20, 1'b1, R_PROGRESS},
    '{8'h34, 32'd21, 1'b1, R_PROGRESS},
    '{8'hAA, 32'd72, 1'b1, R_TIMEOUT},
    // gap of exactly 50 is still fine
    '{8'h01, 32'd122, 1'b1, R_PROGRESS},
    '{8'h02, 32'd123, 1'b1, R_PROGRESS},
    '{8'h00, 32'd124, 1'b1, R_PROGRESS},
    '{8'hFF, 32'd125, 1'b1, R_PROGRESS},
    '{8'hFC, 32'd126, 1'b0, R_NONE},
    // timestamp wraps inside a frame, then the largest length byte
    '{8'hAA, 32'hFFFF_FFFF, 1'b1, R_PROGRESS},
    '{8'h5A, 32'h0000_0020, 1'b1, R_PROGRESS},
    '{8'hFF, 32'h0000_0021, 1'b1, R_ERROR}
  };

  logic [31:0] phase_timeout [N_PHASES] = '{32'd50, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd200,
                                            32'd50};

  serial_frame_parser_xor_timeout_core DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic sfpx_pkg::out_req_t make_result(logic [1:0] st, logic [7:0] cmd,
                                                     logic [4:0] len, logic [7:0] pb,
                                                     logic [3:0] idx, logic lst);
    sfpx_pkg::out_req_t r;
    r.status = st;
    r.command = cmd;
    r.length = len;
    r.payload_byte = pb;
    r.byte_index = idx;
    r.last = lst;
    return r;
  endfunction

  // back to waiting for a start byte; store, time and timeout survive
  function automatic void drop_frame();
    frame_phase = sfpx_pkg::ST_WAIT_SOF;
    frame_cmd = '0;
    frame_len = '0;
    frame_xor = '0;
    fill_ptr = '0;
  endfunction

  // work out what the block owes for one received byte
  function automatic void parse_byte(logic [7:0] b, logic [31:0] t);
    logic [31:0] gap;
    logic [7:0] cmd;
    logic [4:0] len;
    logic sum_ok;
    step_results.delete();
    gap = t - last_ms;
    // stale frame: flush it, then treat the byte as fresh while idle
    if (timeout_q != 0 && frame_phase != sfpx_pkg::ST_WAIT_SOF && gap > timeout_q) begin
      drop_frame();
      if (b == sfpx_pkg::START_BYTE) begin
        frame_phase = sfpx_pkg::ST_CMD;
        last_ms = t;
      end
      step_results.push_back(make_result(sfpx_pkg::STATUS_TIMEOUT, 8'd0, 5'd0, 8'd0, 4'd0,
                                         1'b1));
      return;
    end
    case (frame_phase)
      sfpx_pkg::ST_WAIT_SOF: begin
        if (b == sfpx_pkg::START_BYTE) begin
          frame_phase = sfpx_pkg::ST_CMD;
          last_ms = t;
        end
      end
      sfpx_pkg::ST_CMD: begin
        frame_cmd = b;
        frame_xor = b;
        frame_phase = sfpx_pkg::ST_LEN;
        last_ms = t;
      end
      sfpx_pkg::ST_LEN: begin
        if (b > sfpx_pkg::MAX_PAYLOAD) begin
          drop_frame();
          step_results.push_back(make_result(sfpx_pkg::STATUS_ERROR, 8'd0, 5'd0, 8'd0, 4'd0,
                                             1'b1));
          return;
        end
        frame_len = b[4:0];
        frame_xor = frame_xor ^ b;
        fill_ptr = '0;
        frame_phase = (b == 8'd0) ? sfpx_pkg::ST_SUM : sfpx_pkg::ST_DATA;
        last_ms = t;
      end
      sfpx_pkg::ST_DATA: begin
        if (fill_ptr < sfpx_pkg::MAX_PAYLOAD) payload_mem[fill_ptr[3:0]] = b;
        fill_ptr = fill_ptr + 5'd1;
        frame_xor = frame_xor ^ b;
        if (fill_ptr >= frame_len) frame_phase = sfpx_pkg::ST_SUM;
        last_ms = t;
      end
      sfpx_pkg::ST_SUM: begin
        sum_ok = (b == frame_xor);
        cmd = frame_cmd;
        len = frame_len;
        drop_frame();
        if (!sum_ok) begin
          step_results.push_back(make_result(sfpx_pkg::STATUS_ERROR, 8'd0, 5'd0, 8'd0, 4'd0,
                                             1'b1));
          return;
        end
        if (len == 5'd0) begin
          step_results.push_back(make_result(sfpx_pkg::STATUS_OK, cmd, len, 8'd0, 4'd0, 1'b1));
          return;
        end
        // a good frame reads its payload back one byte per result
        for (int i = 0; i < len; i++)
          step_results.push_back(make_result(sfpx_pkg::STATUS_OK, cmd, len,
                                             payload_mem[i[3:0]], i[3:0], i == len - 1));
        return;
      end
      default: drop_frame();
    endcase
    step_results.push_back(make_result(sfpx_pkg::STATUS_PROGRESS, 8'd0, 5'd0, 8'd0, 4'd0,
                                       1'b1));
  endfunction

  // next arrival time: mostly inside the timeout, sometimes right at it or past it
  function automatic logic [31:0] stamp_next();
    int r;
    logic [31:0] span;
    r = $urandom_range(0, 99);
    span = (timeout_q == 0 || timeout_q > 60) ? 32'd60 : timeout_q;
    if (r < 90) clock_ms = clock_ms + $urandom_range(0, span);
    else if (r < 93) clock_ms = clock_ms + timeout_q;
    else if (r < 96) clock_ms = clock_ms + timeout_q + 32'd1;
    else clock_ms = $urandom();
    return clock_ms;
  endfunction

  // hand one byte to the block and book its results once it is taken
  task automatic offer_byte(input logic [7:0] b, input logic [31:0] t, input bit pinned = 1'b0,
                            input sfpx_pkg::out_req_t want = '0);
    if ($urandom_range(0, 31) == 0) tx_quiet = !tx_quiet;
    if (!calm && !tx_quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {b, t};
    do @(posedge clk); while (in_stall);
    parse_byte(b, t);
    if (pinned) pending_results.push_back(want);
    else foreach (step_results[k]) pending_results.push_back(step_results[k]);
  endtask

  task automatic offer_frame_byte(input logic [7:0] b);
    bytes_offered++;
    offer_byte(b, stamp_next());
  endtask

  // start, command, length, payload, checksum; optionally cut short or corrupted
  task automatic send_frame(input bit corrupt, input bit cut);
    int r;
    int len;
    int stop;
    logic [7:0] cmd;
    logic [7:0] sum;
    logic [7:0] pb;
    r = $urandom_range(0, 9);
    if (r < 6) len = $urandom_range(0, 3);
    else if (r < 9) len = $urandom_range(4, 15);
    else len = sfpx_pkg::MAX_PAYLOAD;
    cmd = 8'($urandom_range(0, 255));
    sum = cmd ^ len[7:0];
    stop = cut ? $urandom_range(0, len) : len;
    offer_frame_byte(sfpx_pkg::START_BYTE);
    offer_frame_byte(cmd);
    offer_frame_byte(len[7:0]);
    for (int i = 0; i < stop; i++) begin
      pb = 8'($urandom_range(0, 255));
      sum = sum ^ pb;
      offer_frame_byte(pb);
    end
    if (!cut) offer_frame_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endtask

  task automatic run_phase(input int n_items);
    int first;
    int pick;
    first = bytes_offered;
    while (bytes_offered - first < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        send_frame(1'b0, 1'b0);
      end else if (pick < 82) begin
        // line noise, mostly ignored while idle
        repeat ($urandom_range(1, 3)) offer_frame_byte(8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        send_frame(1'b1, 1'b0);
      end else if (pick < 94) begin
        send_frame(1'b0, 1'b1);
      end else begin
        // oversize length
        offer_frame_byte(sfpx_pkg::START_BYTE);
        offer_frame_byte(8'($urandom_range(0, 255)));
        offer_frame_byte(8'($urandom_range(sfpx_pkg::MAX_PAYLOAD + 1, 255)));
      end
    end
  endtask

  // timeout is only changed once the block has nothing left in flight
  task automatic set_timeout(input logic [31:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    timeout_q = value;
  endtask

  // receiver side: random stall bursts, one long hold on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (choke_req) begin
        out_stall <= 1'b1;
        repeat (CHOKE_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        choke_req = 1'b0;
      end else if (!calm && !rx_quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 47) == 0) rx_quiet = !rx_quiet;
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        $display("%0t: actual status=%0d cmd=%h len=%0d byte=%h idx=%0d last=%b",
                 $time, out_data.status, out_data.command, out_data.length,
                 out_data.payload_byte, out_data.byte_index, out_data.last);
        mismatches++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_data !== head_result) begin
          $display("%0t: expected status=%0d cmd=%h len=%0d byte=%h idx=%0d last=%b",
                   $time, head_result.status, head_result.command, head_result.length,
                   head_result.payload_byte, head_result.byte_index, head_result.last);
          $display("%0t:   actual status=%0d cmd=%h len=%0d byte=%h idx=%0d last=%b",
                   $time, out_data.status, out_data.command, out_data.length,
                   out_data.payload_byte, out_data.byte_index, out_data.last);
          mismatches++;
        end
      end
    end
  end

  // hang detector
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("serial_frame_parser_xor_timeout_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    idle_cycles = 0;
    mismatches = 0;
    bytes_offered = 0;
    calm = 1'b0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    choke_req = 1'b0;
    clock_ms = 32'h0000_0021;
    drop_frame();
    last_ms = '0;
    timeout_q = sfpx_pkg::TIMEOUT_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows straight after reset
    foreach (dir_rows[i])
      offer_byte(dir_rows[i].b, dir_rows[i].t, dir_rows[i].pinned, dir_rows[i].want);

    // random frames under a range of timeouts, extremes included
    for (int p = 0; p < N_PHASES; p++) begin
      set_timeout(phase_timeout[p]);
      if (p == 1) choke_req = 1'b1;
      if (p == N_PHASES - 1) calm = 1'b1;
      run_phase(PHASE_ITEMS);
    end
    in_valid <= 1'b0;

    // let the last results drain, then a few quiet cycles
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("serial_frame_parser_xor_timeout_core: match");
    end else begin
      $display("serial_frame_parser_xor_timeout_core: mismatch");
    end
    $finish;
  end

endmodule
